// ----- hw/rtl/gcss_pkg.sv -----
// ---------------------------------------------------------------------------
// gcss_pkg
// Shared widths, codes and types of the graph coloring block.
// ---------------------------------------------------------------------------
package gcss_pkg;

  localparam int MAX_NODES  = 32;
  localparam int NODE_W     = 5;
  localparam int COUNT_W    = 6;
  localparam int NUM_COLORS = 16;
  localparam int COLOR_W    = 4;
  localparam int K_W        = 5;
  localparam int COST_W     = 16;
  localparam int OP_W       = 2;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [OP_W-1:0] OP_EDGE  = 2'd0;
  localparam logic [OP_W-1:0] OP_COST  = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  localparam logic REG_K_REGS     = 1'b0;
  localparam logic REG_NODE_COUNT = 1'b1;

  typedef logic [COLOR_W-1:0] color_t;
  typedef color_t [MAX_NODES-1:0] color_arr_t;

  typedef struct packed {
    logic   found;
    color_t color;
  } sel_t;

endpackage

// ----- hw/rtl/gcss_if.sv -----
// ---------------------------------------------------------------------------
// gcss_if
// Valid/ready channels for load and run items and for per-node results.
// ---------------------------------------------------------------------------
interface gcss_req_if;
  logic                         valid;
  logic                         ready;
  logic [gcss_pkg::OP_W-1:0]    op;
  logic [gcss_pkg::NODE_W-1:0]  node_a;
  logic [gcss_pkg::NODE_W-1:0]  node_b;
  logic [gcss_pkg::COST_W-1:0]  cost;
  modport source(output valid, op, node_a, node_b, cost, input ready);
  modport sink(input valid, op, node_a, node_b, cost, output ready);
endinterface

interface gcss_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [gcss_pkg::NODE_W-1:0]  node;
  logic [gcss_pkg::COLOR_W-1:0] color;
  logic                         spilled;
  logic                         was_candidate;
  logic                         last;
  modport source(output valid, node, color, spilled, was_candidate, last, input ready);
  modport sink(input valid, node, color, spilled, was_candidate, last, output ready);
endinterface

// ----- hw/rtl/gcss_ram.sv -----
// ---------------------------------------------------------------------------
// gcss_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module gcss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/gcss_color_sel.sv -----
// ---------------------------------------------------------------------------
// gcss_color_sel
// Finds the lowest color below K that no colored neighbor holds.
// ---------------------------------------------------------------------------
module gcss_color_sel (
  input  logic [gcss_pkg::MAX_NODES-1:0] nb,
  input  gcss_pkg::color_arr_t           colors,
  input  logic [gcss_pkg::K_W-1:0]       k,
  output gcss_pkg::sel_t                 sel
);

  logic [gcss_pkg::NUM_COLORS-1:0] used;
  logic [gcss_pkg::NUM_COLORS:0]   kmask;
  logic [gcss_pkg::NUM_COLORS-1:0] avail;
  logic [gcss_pkg::NUM_COLORS-1:0] lowest;

  always_comb begin
    used = '0;
    for (int i = 0; i < gcss_pkg::MAX_NODES; i++) begin
      if (nb[i]) begin
        used[colors[i]] = 1'b1;
      end
    end
    kmask  = (17'd1 << k) - 17'd1;
    avail  = ~used & kmask[gcss_pkg::NUM_COLORS-1:0];
    lowest = avail & (~avail + 16'd1);
    sel.found = |avail;
    sel.color = '0;
    for (int c = 0; c < gcss_pkg::NUM_COLORS; c++) begin
      if (lowest[c]) begin
        sel.color = sel.color | gcss_pkg::color_t'(c);
      end
    end
  end

endmodule

// ----- hw/rtl/graph_coloring_simplify_select.sv -----
// ---------------------------------------------------------------------------
// graph_coloring_simplify_select
// Chaitin-Briggs simplify and select over a RAM-held interference graph.
// ---------------------------------------------------------------------------
// Items arrive on the req channel. An edge item (op 0) passes ST_EDGE_A and
// ST_EDGE_B: it reads and rewrites the row of each end node in the adjacency
// RAM. A cost item (op 1) and a clear item (op 3) are done on acceptance,
// without leaving the idle state. A run item (op 2) colors nodes 0 to n-1, n
// being node_count capped at 32, then sends one result per node, in node
// order, on the rsp channel, with last set on the final one. Simplify scans
// the nodes from 0 up and restarts after each removed node, with a RAM read,
// then a degree count, per scanned node; select pops each node and tries to
// color it. The adjacency RAM read port is the limiting resource.
// req.ready is high only while no item is in progress. A finished result
// sits in the output register; a stall on rsp holds it and the run waits.
// Reset (rst, synchronous) empties the graph by clearing per-row valid
// bits, zeroes all costs the same way, and loads K = 4 and node_count = 32.
// A clear item drops the same valid bits; no sweep is needed.
// Registers k_regs and node_count sit at APB byte addresses 0 and 4.
// ---------------------------------------------------------------------------
module graph_coloring_simplify_select (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gcss_pkg::PADDR_W-1:0]    paddr,
  input  logic [gcss_pkg::PDATA_W-1:0]    pwdata,
  output logic [gcss_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  gcss_req_if.sink                        req,
  gcss_rsp_if.source                      rsp
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EDGE_A  = 3'd1;
  localparam logic [2:0] ST_EDGE_B  = 3'd2;
  localparam logic [2:0] ST_SCAN_RD = 3'd3;
  localparam logic [2:0] ST_SCAN_EV = 3'd4;
  localparam logic [2:0] ST_POP     = 3'd5;
  localparam logic [2:0] ST_COLOR   = 3'd6;
  localparam logic [2:0] ST_OUT     = 3'd7;

  localparam int N  = gcss_pkg::MAX_NODES;
  localparam int NW = gcss_pkg::NODE_W;
  localparam int CW = gcss_pkg::COUNT_W;

  // Population count in five folding steps.
  function automatic logic [CW-1:0] popcnt(input logic [N-1:0] x);
    logic [N-1:0] a, b, c, d, e;
    a = x - ((x >> 1) & 32'h5555_5555);
    b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
    c = (b + (b >> 4)) & 32'h0F0F_0F0F;
    d = c + (c >> 8);
    e = d + (d >> 16);
    return e[CW-1:0];
  endfunction

  logic [2:0]                      state;
  logic [gcss_pkg::K_W-1:0]        k_regs;
  logic [CW-1:0]                   node_count;
  logic [CW-1:0]                   n;
  logic [gcss_pkg::K_W-1:0]        k;
  logic [NW-1:0]                   ea, eb;
  logic [NW-1:0]                   v;
  logic [NW-1:0]                   pv;
  logic [N-1:0]                    active, colored, cand;
  logic [N-1:0]                    adj_ok, cost_ok;
  logic                            adj_rok, cost_rok;
  logic                            have_best;
  logic [NW-1:0]                   best_node;
  logic [gcss_pkg::COST_W-1:0]     best_cost;
  logic [CW-1:0]                   sp;
  logic [NW-1:0]                   stack [N];
  gcss_pkg::color_arr_t            node_color;
  logic [CW-1:0]                   o_idx;
  logic                            ovalid;

  // RAM ports.
  logic                            adj_we;
  logic [NW-1:0]                   adj_waddr, adj_raddr;
  logic [N-1:0]                    adj_wdata, adj_rdata;
  logic                            cost_we;
  logic [gcss_pkg::COST_W-1:0]     cost_rdata;

  // Derived values.
  logic [CW-1:0]                   sp_m1;
  logic [N-1:0]                    row;
  logic [gcss_pkg::COST_W-1:0]     cst;
  logic [N-1:0]                    vbit;
  logic [CW-1:0]                   deg;
  logic                            is_low, is_last_v, take_v;
  logic                            push_en;
  logic [NW-1:0]                   push_node;
  logic                            push_cand;
  logic [N-1:0]                    act_next;
  logic [N-1:0]                    nb;
  gcss_pkg::sel_t                  sel;
  logic                            req_xfer;
  logic [CW-1:0]                   n_run;
  logic [N:0]                      job_wide;
  logic                            cfg_wr;

  assign req.ready = (state == ST_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign rsp.valid = ovalid;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign prdata    = (paddr[2] == gcss_pkg::REG_NODE_COUNT) ?
                     {{(gcss_pkg::PDATA_W-CW){1'b0}}, node_count} :
                     {{(gcss_pkg::PDATA_W-gcss_pkg::K_W){1'b0}}, k_regs};

  assign sp_m1 = sp - 6'd1;
  assign row   = adj_rok ? adj_rdata : '0;
  assign cst   = cost_rok ? cost_rdata : '0;
  assign vbit  = 32'd1 << v;
  assign n_run = (node_count > 6'(N)) ? 6'(N) : node_count;
  assign job_wide = (33'd1 << n_run) - 33'd1;

  // Read address of the adjacency RAM follows the current phase.
  always_comb begin
    case (state)
      ST_IDLE:   adj_raddr = req.node_a;
      ST_EDGE_A: adj_raddr = eb;
      ST_POP:    adj_raddr = stack[sp_m1[NW-1:0]];
      default:   adj_raddr = v;
    endcase
  end

  // Edge insertion rewrites one row in each of the edge states, ST_EDGE_A and ST_EDGE_B.
  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = ea;
    adj_wdata = row | (32'd1 << eb);
    if (state == ST_EDGE_A) begin
      adj_we = 1'b1;
    end else if (state == ST_EDGE_B) begin
      adj_we    = 1'b1;
      adj_waddr = eb;
      adj_wdata = row | (32'd1 << ea);
    end
  end

  assign cost_we = req_xfer && (req.op == gcss_pkg::OP_COST);

  gcss_ram #(.WIDTH(N), .DEPTH(N)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  gcss_ram #(.WIDTH(gcss_pkg::COST_W), .DEPTH(N)) u_cost (
    .clk   (clk),
    .we    (cost_we),
    .waddr (req.node_a),
    .wdata (req.cost),
    .raddr (v),
    .rdata (cost_rdata)
  );

  // Simplify decision for the node whose row has just come back.
  always_comb begin
    deg       = popcnt(row & active & ~vbit);
    is_low    = active[v] && (deg < {1'b0, k});
    is_last_v = ({1'b0, v} == (n - 6'd1));
    take_v    = active[v] && (!have_best || (cst < best_cost));
    push_en   = 1'b0;
    push_node = v;
    push_cand = 1'b0;
    if (state == ST_SCAN_EV) begin
      if (is_low) begin
        push_en = 1'b1;
      end else if (is_last_v) begin
        push_en   = 1'b1;
        push_cand = 1'b1;
        push_node = take_v ? v : best_node;
      end
    end
    act_next = active & ~(32'd1 << push_node);
  end

  assign nb = row & colored & ~(32'd1 << pv);

  gcss_color_sel u_sel (
    .nb     (nb),
    .colors (node_color),
    .k      (k),
    .sel    (sel)
  );

  // Stack and per-node payload; these need no reset.
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack[sp[NW-1:0]] <= push_node;
      cand[push_node]   <= push_cand;
    end
    if (state == ST_COLOR && sel.found) begin
      node_color[pv] <= sel.color;
    end
    if (state == ST_POP) begin
      pv <= stack[sp_m1[NW-1:0]];
    end
    if (state == ST_IDLE) begin
      ea <= req.node_a;
      eb <= req.node_b;
    end
    adj_rok  <= adj_ok[adj_raddr];
    cost_rok <= cost_ok[v];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == ST_OUT && (!ovalid || rsp.ready)) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!ovalid || rsp.ready)) begin
      rsp.node          <= o_idx[NW-1:0];
      rsp.color         <= colored[o_idx[NW-1:0]] ? node_color[o_idx[NW-1:0]] : '0;
      rsp.spilled       <= !colored[o_idx[NW-1:0]];
      rsp.was_candidate <= cand[o_idx[NW-1:0]];
      rsp.last          <= (o_idx == (n - 6'd1));
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      k_regs     <= 5'd4;
      node_count <= 6'd32;
    end else if (cfg_wr && pready) begin
      if (paddr[2] == gcss_pkg::REG_K_REGS) begin
        k_regs <= pwdata[gcss_pkg::K_W-1:0];
      end else begin
        node_count <= pwdata[CW-1:0];
      end
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      adj_ok    <= '0;
      cost_ok   <= '0;
      active    <= '0;
      colored   <= '0;
      sp        <= '0;
      v         <= '0;
      have_best <= 1'b0;
      o_idx     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_xfer) begin
            case (req.op)
              gcss_pkg::OP_EDGE: begin
                if (req.node_a != req.node_b) begin
                  state <= ST_EDGE_A;
                end
              end
              gcss_pkg::OP_COST: begin
                cost_ok[req.node_a] <= 1'b1;
              end
              gcss_pkg::OP_RUN: begin
                n         <= n_run;
                k         <= (k_regs > 5'd16) ? 5'd16 : k_regs;
                active    <= job_wide[N-1:0];
                colored   <= '0;
                sp        <= '0;
                v         <= '0;
                have_best <= 1'b0;
                if (n_run != '0) begin
                  state <= ST_SCAN_RD;
                end
              end
              default: begin
                adj_ok  <= '0;
                cost_ok <= '0;
              end
            endcase
          end
        end
        ST_EDGE_A: begin
          adj_ok[ea] <= 1'b1;
          state      <= ST_EDGE_B;
        end
        ST_EDGE_B: begin
          adj_ok[eb] <= 1'b1;
          state      <= ST_IDLE;
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_EV;
        end
        ST_SCAN_EV: begin
          if (push_en) begin
            active    <= act_next;
            sp        <= sp + 6'd1;
            v         <= '0;
            have_best <= 1'b0;
            state     <= (act_next == '0) ? ST_POP : ST_SCAN_RD;
          end else begin
            if (take_v) begin
              have_best <= 1'b1;
              best_node <= v;
              best_cost <= cst;
            end
            v     <= v + 5'd1;
            state <= ST_SCAN_RD;
          end
        end
        ST_POP: begin
          if (sp == '0) begin
            o_idx <= '0;
            state <= ST_OUT;
          end else begin
            sp    <= sp_m1;
            state <= ST_COLOR;
          end
        end
        ST_COLOR: begin
          if (sel.found) begin
            colored[pv] <= 1'b1;
          end
          state <= ST_POP;
        end
        ST_OUT: begin
          if (!ovalid || rsp.ready) begin
            o_idx <= o_idx + 6'd1;
            if (o_idx == (n - 6'd1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/gcss_chk.sv -----
// ---------------------------------------------------------------------------
// gcss_chk
// Port-level checks of the graph coloring block, bound to its top level.
// ---------------------------------------------------------------------------
module gcss_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic [gcss_pkg::OP_W-1:0]      req_op,
  input logic [gcss_pkg::NODE_W-1:0]    req_node_a,
  input logic [gcss_pkg::NODE_W-1:0]    req_node_b,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [gcss_pkg::COLOR_W-1:0]   rsp_color,
  input logic                           rsp_spilled
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A spilled node reports color zero.
  a_spill_color: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_spilled) |-> (rsp_color == '0))
    else $error("spilled result with nonzero color");

  // An edge between two distinct nodes keeps the input busy afterwards.
  a_edge_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_op == gcss_pkg::OP_EDGE && req_node_a != req_node_b)
    |=> !req_ready)
    else $error("input ready during edge update");

  // A stalled result stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result dropped while stalled");

endmodule

bind graph_coloring_simplify_select gcss_chk u_gcss_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_op      (req.op),
  .req_node_a  (req.node_a),
  .req_node_b  (req.node_b),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_color   (rsp.color),
  .rsp_spilled (rsp.spilled)
);
